// ===== design/chunked_transfer_decoder_assert.svh =====
// Assertion macros for the chunked transfer decoder.
// No dependencies; taken in by `include where assertions are written.
`ifndef CHUNKED_TRANSFER_DECODER_ASSERT_SVH
`define CHUNKED_TRANSFER_DECODER_ASSERT_SVH

// Clocked check, held off while reset is asserted.
`define CTD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("chunked_transfer_decoder: assertion failed");

// Clocked check that also holds during reset.
`define CTD_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("chunked_transfer_decoder: assertion failed");

`endif

// ===== design/ctd_pkg.sv =====
// Shared types, codes and helpers for the chunked transfer decoder.
// No dependencies.
package ctd_pkg;

  localparam int unsigned SIZE_BITS_DEF = 32;
  localparam int unsigned HEX_BITS      = 4;   // one hex digit per size byte

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // framing phases
  localparam logic [2:0] PH_SIZE     = 3'd0;
  localparam logic [2:0] PH_SIZE_LF  = 3'd1;
  localparam logic [2:0] PH_DATA     = 3'd2;
  localparam logic [2:0] PH_DATA_CR  = 3'd3;
  localparam logic [2:0] PH_DATA_LF  = 3'd4;
  localparam logic [2:0] PH_TRAILERS = 3'd5;

  // parse status
  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  // byte kinds
  localparam logic [1:0] KIND_FRAME   = 2'd0;
  localparam logic [1:0] KIND_BODY    = 2'd1;
  localparam logic [1:0] KIND_TRAILER = 2'd2;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } ctd_hex_t;

  typedef struct packed {
    logic [1:0] parse_status;
    logic       end_of_chunk;
    logic [1:0] byte_kind;
    logic [7:0] out_byte;
  } ctd_result_t;

  function automatic ctd_hex_t hex_decode(input logic [7:0] b);
    ctd_hex_t h;
    h.valid = 1'b1;
    h.value = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.value = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.value = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.value = 4'(b - 8'h37);
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

endpackage

// ===== design/chunked_transfer_decoder.sv =====
// Top level of the chunked transfer decoder: input slice, parser, output slice.
// Depends on ctd_pkg, ctd_pipe_reg and ctd_parser.
//
//  channel  dir  tdata                         tuser       tlast
//  s_axis   in   [7:0] data_byte               -           -
//  m_axis   out  [7:0] out_byte,               [1:0]       end_of_chunk
//                [9:8] parse_status, pad to 16  byte_kind
//
// One word per cycle sustained while m_axis is ready; a byte accepted on s_axis
// sits in the input slice, is classified into the result slice and then leaves
// m_axis. The parser state advances only when a byte moves from the input slice
// into the output slice, so a stalled m_axis holds the state and back-pressures
// s_axis once both slices are full. Reset (rst_ni low, asynchronous) empties both
// slices and returns the parser to the size line phase.
module chunked_transfer_decoder #(
  parameter int unsigned SIZE_BITS = ctd_pkg::SIZE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] out_byte, [9:8] parse_status, rest zero
  output logic [1:0]  m_axis_tuser_o,   // [1:0] byte_kind
  output logic        m_axis_tlast_o    // end_of_chunk
);

  localparam int unsigned ResW = $bits(ctd_pkg::ctd_result_t);

  logic                 in_valid;
  logic                 in_ready;
  logic [7:0]           in_byte;
  ctd_pkg::ctd_result_t res;
  logic [ResW-1:0]      out_word;

  // input slice: holds the byte under classification
  ctd_pipe_reg #(
    .WIDTH (8)
  ) u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .data_i  (s_axis_tdata_i),
    .valid_o (in_valid),
    .ready_i (in_ready),
    .data_o  (in_byte)
  );

  // parser consumes the held byte only when the result slice can take it
  ctd_parser #(
    .SIZE_BITS (SIZE_BITS)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (in_valid && in_ready),
    .byte_i (in_byte),
    .res_o  (res)
  );

  // result slice
  ctd_pipe_reg #(
    .WIDTH (ResW)
  ) u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid),
    .ready_o (in_ready),
    .data_i  (res),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (out_word)
  );

  ctd_pkg::ctd_result_t out_res;
  assign out_res = ctd_pkg::ctd_result_t'(out_word);

  assign m_axis_tdata_o = {6'd0, out_res.parse_status, out_res.out_byte};
  assign m_axis_tuser_o = out_res.byte_kind;
  assign m_axis_tlast_o = out_res.end_of_chunk;

endmodule

// ===== design/ctd_pipe_reg.sv =====
// Valid/ready register slice carrying one word of WIDTH bits.
// No dependencies.
module ctd_pipe_reg #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [WIDTH-1:0] data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [WIDTH-1:0] data_o
);

  logic             valid_q;
  logic [WIDTH-1:0] data_q;

  // refill whenever empty or the held word leaves this cycle
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== design/ctd_parser.sv =====
// Framing state and per-byte classification of the chunked decoder.
// Depends on ctd_pkg and chunked_transfer_decoder_assert.svh.
`include "chunked_transfer_decoder_assert.svh"

module ctd_parser #(
  parameter int unsigned SIZE_BITS = ctd_pkg::SIZE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,     // byte is consumed this cycle
  input  logic [7:0]          byte_i,
  output ctd_pkg::ctd_result_t res_o
);

  logic [2:0]           phase_q, phase_d;
  logic [SIZE_BITS-1:0] accum_q, accum_d;
  logic                 nonempty_q, nonempty_d;
  logic                 bad_q, bad_d;
  logic [SIZE_BITS-1:0] left_q, left_d;
  logic [1:0]           status_q, status_d;

  always_comb begin
    ctd_pkg::ctd_hex_t hex;
    logic [1:0] kind;
    logic       eoc;
    hex        = ctd_pkg::hex_decode(byte_i);
    kind       = ctd_pkg::KIND_FRAME;
    eoc        = 1'b0;
    phase_d    = phase_q;
    accum_d    = accum_q;
    nonempty_d = nonempty_q;
    bad_d      = bad_q;
    left_d     = left_q;
    status_d   = status_q;

    if (status_q == ctd_pkg::ST_BAD) begin
      kind = ctd_pkg::KIND_FRAME;
    end else if (status_q == ctd_pkg::ST_DONE) begin
      kind = ctd_pkg::KIND_TRAILER;
    end else begin
      unique case (phase_q)
        ctd_pkg::PH_SIZE: begin
          if (byte_i == ctd_pkg::CH_CR) begin
            phase_d = ctd_pkg::PH_SIZE_LF;
          end else if (byte_i == ctd_pkg::CH_LF) begin
            status_d = ctd_pkg::ST_BAD;
          end else begin
            nonempty_d = 1'b1;
            if (!hex.valid) begin
              bad_d = 1'b1;
            end else if (!bad_q) begin
              // top digit occupied: one more digit would overflow
              if (accum_q[SIZE_BITS-1 -: ctd_pkg::HEX_BITS] != '0) begin
                bad_d = 1'b1;
              end else begin
                accum_d = {accum_q[SIZE_BITS-ctd_pkg::HEX_BITS-1:0], hex.value};
              end
            end
          end
        end
        ctd_pkg::PH_SIZE_LF: begin
          if (byte_i != ctd_pkg::CH_LF || !nonempty_q || bad_q) begin
            status_d = ctd_pkg::ST_BAD;
          end else begin
            left_d     = accum_q;
            accum_d    = '0;
            nonempty_d = 1'b0;
            bad_d      = 1'b0;
            if (accum_q == '0) begin
              phase_d  = ctd_pkg::PH_TRAILERS;
              status_d = ctd_pkg::ST_DONE;
            end else begin
              phase_d = ctd_pkg::PH_DATA;
            end
          end
        end
        ctd_pkg::PH_DATA: begin
          kind   = ctd_pkg::KIND_BODY;
          left_d = left_q - SIZE_BITS'(1);
          if (left_q == SIZE_BITS'(1)) begin
            eoc     = 1'b1;
            phase_d = ctd_pkg::PH_DATA_CR;
          end
        end
        ctd_pkg::PH_DATA_CR: begin
          if (byte_i != ctd_pkg::CH_CR) status_d = ctd_pkg::ST_BAD;
          else                          phase_d  = ctd_pkg::PH_DATA_LF;
        end
        ctd_pkg::PH_DATA_LF: begin
          if (byte_i != ctd_pkg::CH_LF) status_d = ctd_pkg::ST_BAD;
          else                          phase_d  = ctd_pkg::PH_SIZE;
        end
        default: begin
          phase_d  = ctd_pkg::PH_TRAILERS;
          status_d = ctd_pkg::ST_DONE;
          kind     = ctd_pkg::KIND_TRAILER;
        end
      endcase
    end

    res_o.out_byte     = byte_i;
    res_o.byte_kind    = kind;
    res_o.end_of_chunk = eoc;
    res_o.parse_status = status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= ctd_pkg::PH_SIZE;
      accum_q    <= '0;
      nonempty_q <= 1'b0;
      bad_q      <= 1'b0;
      left_q     <= '0;
      status_q   <= ctd_pkg::ST_RUN;
    end else if (adv_i) begin
      phase_q    <= phase_d;
      accum_q    <= accum_d;
      nonempty_q <= nonempty_d;
      bad_q      <= bad_d;
      left_q     <= left_d;
      status_q   <= status_d;
    end
  end

  // invalid and done are both terminal
  `CTD_ASSERT(a_bad_sticky, clk_i, rst_ni, status_q == ctd_pkg::ST_BAD |=> status_q == ctd_pkg::ST_BAD)
  `CTD_ASSERT(a_done_sticky, clk_i, rst_ni, status_q == ctd_pkg::ST_DONE |=> status_q == ctd_pkg::ST_DONE)
  // a running data phase always has payload left
  `CTD_ASSERT(a_data_left, clk_i, rst_ni, (phase_q == ctd_pkg::PH_DATA && status_q == ctd_pkg::ST_RUN) |-> left_q != '0)

endmodule
